// File: hw/rtl/sot_pkg.sv
package sot_pkg;

    // fixed field widths of the ports
    localparam int CMD_W    = 3;
    localparam int PID_W    = 5;
    localparam int OID_W    = 7;
    localparam int CNT_IN_W = 16;
    localparam int ST_W     = 3;
    localparam int KIND_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NEW_PROC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END_PROC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEW_MUTEX = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEW_SEM   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEW_EVENT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WAIT      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd6;

    // object kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MUTEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEM   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_PROC  = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_OBJ   = 3'd2;
    localparam logic [ST_W-1:0] ST_REFUSED   = 3'd3;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd4;

    // classified command as it travels through the queue
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [PID_W-1:0]    pid;
        logic [OID_W-1:0]    oid;
        logic                pid_in_range;
        logic                oid_in_range;
        logic [CNT_IN_W-1:0] init_count;
        logic [CNT_IN_W-1:0] max_count;
        logic                manual;
        logic                istate;
    } t_item;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hw/rtl/sot_front.sv
module sot_front import sot_pkg::*; #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_OBJECTS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [PID_W-1:0]    i_process_id,
    input  logic [OID_W-1:0]    i_object_id,
    input  logic [CNT_IN_W-1:0] i_initial_count,
    input  logic [CNT_IN_W-1:0] i_maximum_count,
    input  logic                i_manual_reset,
    input  logic                i_initial_state,
    input  t_q_status           i_q_stat,
    output logic                o_push,
    output t_item               o_item
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    t_item n_item;
    logic  accept;

    // hand the held item on whenever the queue has room
    assign o_push = r_vld && !i_q_stat.full;
    assign o_busy = r_vld && i_q_stat.full;
    assign accept = i_start && !o_busy;
    assign o_item = r_item;

    // classify: identifier range checks, no table state needed
    always_comb begin
        n_item.cmd          = i_cmd;
        n_item.pid          = i_process_id;
        n_item.oid          = i_object_id;
        n_item.pid_in_range = (i_process_id != '0) &&
                              (32'(i_process_id) <= 32'(MAX_PROCESSES));
        n_item.oid_in_range = (i_object_id != '0) &&
                              (32'(i_object_id) <= 32'(MAX_OBJECTS));
        n_item.init_count   = i_initial_count;
        n_item.max_count    = i_maximum_count;
        n_item.manual       = i_manual_reset;
        n_item.istate       = i_initial_state;
    end

    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: hw/rtl/sot_queue.sv
module sot_queue import sot_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_stat
);

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_item       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // two-entry fifo between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hw/rtl/sot_back.sv
module sot_back import sot_pkg::*; #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_OBJECTS   = 64,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_status        i_q_stat,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    output logic             o_ok,
    output logic [ST_W-1:0]  o_status,
    output logic [OID_W-1:0] o_new_id
);

    localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int OIDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int NPW    = $clog2(MAX_PROCESSES + 2);
    localparam int NOW    = $clog2(MAX_OBJECTS + 2);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic                   flag;
        logic                   manual;
        logic [PID_W-1:0]       owner;
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] limit;
    } t_entry;

    logic                     r_state;
    t_item                    r_cur;
    t_entry                   r_rd;
    t_entry                   r_mem [MAX_OBJECTS];
    logic [MAX_PROCESSES-1:0] r_live;
    logic [NPW-1:0]           r_next_proc;
    logic [NOW-1:0]           r_next_obj;
    logic                     r_valid;
    logic                     r_ok;
    logic [ST_W-1:0]          r_status;
    logic [OID_W-1:0]         r_new_id;

    logic              n_ok;
    logic [ST_W-1:0]   n_status;
    logic [OID_W-1:0]  n_new_id;
    logic              we;
    logic [OIDX_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              live_set;
    logic              live_clr;
    logic [PIDX_W-1:0] live_idx;
    logic              inc_proc;
    logic              inc_obj;
    logic              exec;

    logic [31:0]       rd_oid_m1;
    logic [OIDX_W-1:0] rd_addr;
    logic [31:0]       pid_m1;
    logic [31:0]       oid_m1;
    logic [31:0]       nproc_m1;
    logic [31:0]       nobj_m1;
    logic [31:0]       nproc_ext;
    logic [31:0]       nobj_ext;
    logic [31:0]       init_ext;
    logic [31:0]       max_ext;
    logic              proc_ok;
    logic              obj_ok;

    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign exec     = (r_state == S_EXEC);
    assign o_valid  = r_valid;
    assign o_ok     = r_ok;
    assign o_status = r_status;
    assign o_new_id = r_new_id;

    // slot lookups and identifier checks against live state
    assign rd_oid_m1 = 32'(i_item.oid) - 32'd1;
    assign rd_addr   = rd_oid_m1[OIDX_W-1:0];
    assign pid_m1    = 32'(r_cur.pid) - 32'd1;
    assign oid_m1    = 32'(r_cur.oid) - 32'd1;
    assign nproc_ext = 32'(r_next_proc);
    assign nobj_ext  = 32'(r_next_obj);
    assign nproc_m1  = nproc_ext - 32'd1;
    assign nobj_m1   = nobj_ext - 32'd1;
    assign init_ext  = 32'(r_cur.init_count);
    assign max_ext   = 32'(r_cur.max_count);
    assign proc_ok   = r_cur.pid_in_range && r_live[pid_m1[PIDX_W-1:0]];
    // objects are handed out in order and never freed
    assign obj_ok    = r_cur.oid_in_range && (32'(r_cur.oid) < nobj_ext);

    // execute one command on the entry read in the previous cycle
    always_comb begin
        n_ok     = 1'b0;
        n_status = ST_REFUSED;
        n_new_id = '0;
        we       = 1'b0;
        wr_addr  = oid_m1[OIDX_W-1:0];
        wr_data  = r_rd;
        live_set = 1'b0;
        live_clr = 1'b0;
        live_idx = pid_m1[PIDX_W-1:0];
        inc_proc = 1'b0;
        inc_obj  = 1'b0;
        case (r_cur.cmd)
            CMD_NEW_PROC: begin
                if (nproc_ext > 32'(MAX_PROCESSES)) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    live_set = 1'b1;
                    live_idx = nproc_m1[PIDX_W-1:0];
                    inc_proc = 1'b1;
                    n_ok     = 1'b1;
                    n_status = ST_DONE;
                    n_new_id = nproc_ext[OID_W-1:0];
                end
            end
            CMD_END_PROC: begin
                if (!proc_ok) begin
                    n_status = ST_BAD_PROC;
                end else begin
                    live_clr = 1'b1;
                    n_ok     = 1'b1;
                    n_status = ST_DONE;
                end
            end
            CMD_NEW_MUTEX, CMD_NEW_SEM, CMD_NEW_EVENT: begin
                if (!proc_ok) begin
                    n_status = ST_BAD_PROC;
                end else if (nobj_ext > 32'(MAX_OBJECTS)) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    we             = 1'b1;
                    wr_addr        = nobj_m1[OIDX_W-1:0];
                    wr_data.kind   = KIND_MUTEX;
                    wr_data.flag   = 1'b0;
                    wr_data.manual = 1'b0;
                    wr_data.owner  = '0;
                    wr_data.count  = '0;
                    wr_data.limit  = '0;
                    if (r_cur.cmd == CMD_NEW_SEM) begin
                        wr_data.kind  = KIND_SEM;
                        wr_data.count = init_ext[COUNT_WIDTH-1:0];
                        wr_data.limit = max_ext[COUNT_WIDTH-1:0];
                    end else if (r_cur.cmd == CMD_NEW_EVENT) begin
                        wr_data.kind   = KIND_EVENT;
                        wr_data.flag   = r_cur.istate;
                        wr_data.manual = r_cur.manual;
                    end
                    inc_obj  = 1'b1;
                    n_ok     = 1'b1;
                    n_status = ST_DONE;
                    n_new_id = nobj_ext[OID_W-1:0];
                end
            end
            CMD_WAIT, CMD_RELEASE: begin
                if (!proc_ok) begin
                    n_status = ST_BAD_PROC;
                end else if (!obj_ok) begin
                    n_status = ST_BAD_OBJ;
                end else begin
                    case (r_rd.kind)
                        KIND_MUTEX: begin
                            if (r_cur.cmd == CMD_WAIT) begin
                                if (!r_rd.flag) begin
                                    wr_data.flag  = 1'b1;
                                    wr_data.owner = r_cur.pid;
                                    n_ok          = 1'b1;
                                end
                            end else if (r_rd.flag && (r_rd.owner == r_cur.pid)) begin
                                wr_data.flag  = 1'b0;
                                wr_data.owner = '0;
                                n_ok          = 1'b1;
                            end
                        end
                        KIND_SEM: begin
                            if (r_cur.cmd == CMD_WAIT) begin
                                if (r_rd.count != '0) begin
                                    wr_data.count = r_rd.count - COUNT_WIDTH'(1);
                                    n_ok          = 1'b1;
                                end
                            end else if (r_rd.count < r_rd.limit) begin
                                wr_data.count = r_rd.count + COUNT_WIDTH'(1);
                                n_ok          = 1'b1;
                            end
                        end
                        default: begin
                            if (r_cur.cmd == CMD_WAIT) begin
                                if (r_rd.flag) begin
                                    if (!r_rd.manual) begin
                                        wr_data.flag = 1'b0;
                                    end
                                    n_ok = 1'b1;
                                end
                            end else begin
                                wr_data.flag = 1'b1;
                                n_ok         = 1'b1;
                            end
                        end
                    endcase
                    we       = n_ok;
                    n_status = n_ok ? ST_DONE : ST_REFUSED;
                end
            end
            default: begin
                n_status = ST_REFUSED;
            end
        endcase
    end

    // sequencer, process bitmap, identifier counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_next_proc <= NPW'(1);
            r_next_obj  <= NOW'(1);
            r_valid     <= 1'b0;
        end else begin
            r_valid <= exec;
            if (o_pop) begin
                r_state <= S_EXEC;
            end else if (exec) begin
                r_state <= S_IDLE;
            end
            if (exec && live_set) begin
                r_live[live_idx] <= 1'b1;
            end
            if (exec && live_clr) begin
                r_live[live_idx] <= 1'b0;
            end
            if (exec && inc_proc) begin
                r_next_proc <= r_next_proc + NPW'(1);
            end
            if (exec && inc_obj) begin
                r_next_obj <= r_next_obj + NOW'(1);
            end
        end
        if (o_pop) begin
            r_cur <= i_item;
        end
        if (exec) begin
            r_ok     <= n_ok;
            r_status <= n_status;
            r_new_id <= n_new_id;
        end
    end

    // object store: read on transfer from the queue, write on execute
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[rd_addr];
        end
        if (exec && we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/sync_object_table.sv
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+-----------------------
// command   | i_cmd i_process_id i_object_id i_initial_count  | start high, busy low
//           | i_maximum_count i_manual_reset i_initial_state  |
// result    | o_ok o_status o_new_id                          | o_valid, one cycle
//
// the front takes one command per cycle, while busy is low, into a two-entry queue; busy
// is high only while the front register and the queue are both full.
// the back handles each command in two steps (store read, then write and result) and
// pops the next one from the queue only after the last has executed.
// synchronous reset clears the process bitmap and sets both identifier counters to one.
// the receiver cannot stall: each result is on the ports for one cycle only.
module sync_object_table import sot_pkg::*; #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_OBJECTS   = 64,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [PID_W-1:0]    i_process_id,
    input  logic [OID_W-1:0]    i_object_id,
    input  logic [CNT_IN_W-1:0] i_initial_count,
    input  logic [CNT_IN_W-1:0] i_maximum_count,
    input  logic                i_manual_reset,
    input  logic                i_initial_state,
    output logic                o_valid,
    output logic                o_ok,
    output logic [ST_W-1:0]     o_status,
    output logic [OID_W-1:0]    o_new_id
);

    t_q_status q_stat;
    t_item     front_item;
    t_item     q_item;
    logic      push;
    logic      pop;

    // accept and classify
    sot_front #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_OBJECTS   (MAX_OBJECTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_cmd           (i_cmd),
        .i_process_id    (i_process_id),
        .i_object_id     (i_object_id),
        .i_initial_count (i_initial_count),
        .i_maximum_count (i_maximum_count),
        .i_manual_reset  (i_manual_reset),
        .i_initial_state (i_initial_state),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_item          (front_item)
    );

    // decoupling queue
    sot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // execute against the tables
    sot_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_OBJECTS   (MAX_OBJECTS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_ok     (o_ok),
        .o_status (o_status),
        .o_new_id (o_new_id)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sot_pkg::*;

    localparam int N_PROC      = 16;
    localparam int N_OBJ       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_CALLS = 500;

    // command code with no meaning in the block
    localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;

    // one command as queued for the driver, with its pacing attached
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [PID_W-1:0]    pid;
        logic [OID_W-1:0]    oid;
        logic [CNT_IN_W-1:0] init_cnt;
        logic [CNT_IN_W-1:0] max_cnt;
        logic                manual;
        logic                istate;
        logic                drain;
        logic [6:0]          idle;
    } t_call;

    // one answer of the block
    typedef struct packed {
        logic            ok;
        logic [ST_W-1:0] status;
        logic [OID_W-1:0] new_id;
    } t_answer;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd           = '0;
    logic [PID_W-1:0]    i_process_id    = '0;
    logic [OID_W-1:0]    i_object_id     = '0;
    logic [CNT_IN_W-1:0] i_initial_count = '0;
    logic [CNT_IN_W-1:0] i_maximum_count = '0;
    logic                i_manual_reset  = 1'b0;
    logic                i_initial_state = 1'b0;
    logic                o_valid;
    logic                o_ok;
    logic [ST_W-1:0]     o_status;
    logic [OID_W-1:0]    o_new_id;

    t_call   call_q[$];
    t_answer answer_q[$];
    t_call   drv_call  = '0;
    bit      xfer_seen = 1'b0;
    int      n_errors  = 0;
    int      n_cycles  = 0;

    // predicted contents of the process bitmap and object table
    logic                tbl_live   [1:N_PROC];
    int                  tbl_next_pid;
    int                  tbl_next_oid;
    logic [KIND_W-1:0]   tbl_kind   [1:N_OBJ];
    logic                tbl_flag   [1:N_OBJ];
    logic                tbl_manual [1:N_OBJ];
    logic [PID_W-1:0]    tbl_owner  [1:N_OBJ];
    logic [CNT_IN_W-1:0] tbl_count  [1:N_OBJ];
    logic [CNT_IN_W-1:0] tbl_limit  [1:N_OBJ];

    // rough view of the table kept while building stimulus, to aim commands
    logic             plan_live   [1:N_PROC];
    int               plan_next_pid;
    int               plan_next_oid;
    logic [PID_W-1:0] plan_waiter [1:N_OBJ];
    logic [6:0]       gen_idle  = 7'd0;
    logic             gen_drain = 1'b0;

    sync_object_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_process_id    (i_process_id),
        .i_object_id     (i_object_id),
        .i_initial_count (i_initial_count),
        .i_maximum_count (i_maximum_count),
        .i_manual_reset  (i_manual_reset),
        .i_initial_state (i_initial_state),
        .o_valid         (o_valid),
        .o_ok            (o_ok),
        .o_status        (o_status),
        .o_new_id        (o_new_id)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // apply one command to the predicted table and give its answer
    function automatic t_answer table_step(input t_call c);
        t_answer a;
        logic    pid_ok;
        logic    oid_ok;
        logic    done;
        int      s;
        a.ok     = 1'b0;
        a.status = ST_REFUSED;
        a.new_id = '0;
        pid_ok   = 1'b0;
        oid_ok   = 1'b0;
        done     = 1'b0;
        if (c.pid >= 1 && c.pid <= N_PROC) pid_ok = tbl_live[c.pid];
        if (c.oid >= 1 && c.oid <= N_OBJ) oid_ok = (tbl_kind[c.oid] != KIND_NONE);
        case (c.cmd)
            CMD_NEW_PROC: begin
                if (tbl_next_pid > N_PROC) begin
                    a.status = ST_EXHAUSTED;
                end else begin
                    tbl_live[tbl_next_pid] = 1'b1;
                    a.ok     = 1'b1;
                    a.status = ST_DONE;
                    a.new_id = OID_W'(tbl_next_pid);
                    tbl_next_pid++;
                end
            end
            CMD_END_PROC: begin
                if (!pid_ok) begin
                    a.status = ST_BAD_PROC;
                end else begin
                    tbl_live[c.pid] = 1'b0;
                    a.ok     = 1'b1;
                    a.status = ST_DONE;
                end
            end
            CMD_NEW_MUTEX, CMD_NEW_SEM, CMD_NEW_EVENT: begin
                if (!pid_ok) begin
                    a.status = ST_BAD_PROC;
                end else if (tbl_next_oid > N_OBJ) begin
                    a.status = ST_EXHAUSTED;
                end else begin
                    s = tbl_next_oid;
                    tbl_kind[s]   = (c.cmd == CMD_NEW_MUTEX) ? KIND_MUTEX :
                                    (c.cmd == CMD_NEW_SEM)   ? KIND_SEM : KIND_EVENT;
                    tbl_flag[s]   = (c.cmd == CMD_NEW_EVENT) ? c.istate : 1'b0;
                    tbl_manual[s] = (c.cmd == CMD_NEW_EVENT) ? c.manual : 1'b0;
                    tbl_owner[s]  = '0;
                    tbl_count[s]  = (c.cmd == CMD_NEW_SEM) ? c.init_cnt : '0;
                    tbl_limit[s]  = (c.cmd == CMD_NEW_SEM) ? c.max_cnt : '0;
                    a.ok     = 1'b1;
                    a.status = ST_DONE;
                    a.new_id = OID_W'(s);
                    tbl_next_oid++;
                end
            end
            CMD_WAIT, CMD_RELEASE: begin
                if (!pid_ok) begin
                    a.status = ST_BAD_PROC;
                end else if (!oid_ok) begin
                    a.status = ST_BAD_OBJ;
                end else begin
                    s = c.oid;
                    case (tbl_kind[s])
                        KIND_MUTEX: begin
                            if (c.cmd == CMD_WAIT) begin
                                if (!tbl_flag[s]) begin
                                    tbl_flag[s]  = 1'b1;
                                    tbl_owner[s] = c.pid;
                                    done = 1'b1;
                                end
                            end else if (tbl_flag[s] && tbl_owner[s] == c.pid) begin
                                tbl_flag[s]  = 1'b0;
                                tbl_owner[s] = '0;
                                done = 1'b1;
                            end
                        end
                        KIND_SEM: begin
                            if (c.cmd == CMD_WAIT) begin
                                if (tbl_count[s] != 0) begin
                                    tbl_count[s] = tbl_count[s] - CNT_IN_W'(1);
                                    done = 1'b1;
                                end
                            end else if (tbl_count[s] < tbl_limit[s]) begin
                                tbl_count[s] = tbl_count[s] + CNT_IN_W'(1);
                                done = 1'b1;
                            end
                        end
                        default: begin
                            if (c.cmd == CMD_WAIT) begin
                                if (tbl_flag[s]) begin
                                    if (!tbl_manual[s]) tbl_flag[s] = 1'b0;
                                    done = 1'b1;
                                end
                            end else begin
                                tbl_flag[s] = 1'b1;
                                done = 1'b1;
                            end
                        end
                    endcase
                    a.ok     = done;
                    a.status = done ? ST_DONE : ST_REFUSED;
                end
            end
            default: a.status = ST_REFUSED;
        endcase
        return a;
    endfunction

    // queue a command for the driver and track roughly what it will do
    task automatic queue_call(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
                              input logic [OID_W-1:0] oid, input logic [CNT_IN_W-1:0] ic,
                              input logic [CNT_IN_W-1:0] mc, input logic man,
                              input logic ist);
        t_call c;
        logic  pid_ok;
        c = '{cmd: cmd, pid: pid, oid: oid, init_cnt: ic, max_cnt: mc, manual: man,
              istate: ist, drain: gen_drain, idle: gen_idle};
        call_q.insert(call_q.size(), c);
        gen_drain = 1'b0;
        pid_ok = 1'b0;
        if (pid >= 1 && pid <= N_PROC) pid_ok = plan_live[pid];
        if (cmd == CMD_NEW_PROC && plan_next_pid <= N_PROC) begin
            plan_live[plan_next_pid] = 1'b1;
            plan_next_pid++;
        end else if (cmd == CMD_END_PROC && pid_ok) begin
            plan_live[pid] = 1'b0;
        end else if ((cmd == CMD_NEW_MUTEX || cmd == CMD_NEW_SEM || cmd == CMD_NEW_EVENT)
                     && pid_ok && plan_next_oid <= N_OBJ) begin
            plan_next_oid++;
        end else if (cmd == CMD_WAIT && pid_ok && oid >= 1 && oid < plan_next_oid) begin
            plan_waiter[oid] = pid;
        end
    endtask

    function automatic int plan_live_count();
        int n;
        n = 0;
        for (int i = 1; i <= N_PROC; i++) if (plan_live[i]) n++;
        return n;
    endfunction

    // a live process if there is one, else any in range
    function automatic logic [PID_W-1:0] pick_live_pid();
        int pool[$];
        for (int i = 1; i <= N_PROC; i++) if (plan_live[i]) pool.insert(pool.size(), i);
        if (pool.size() == 0) return PID_W'($urandom_range(1, N_PROC));
        return PID_W'(pool[$urandom_range(0, pool.size() - 1)]);
    endfunction

    function automatic logic [OID_W-1:0] pick_object();
        if (plan_next_oid <= 1) return OID_W'(1);
        return OID_W'($urandom_range(1, plan_next_oid - 1));
    endfunction

    // semaphore counts: mostly small so the limits are hit, sometimes extreme
    function automatic logic [CNT_IN_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return CNT_IN_W'($urandom_range(0, 3));
        if (r == 6) return '0;
        if (r == 7) return '1;
        return CNT_IN_W'($urandom());
    endfunction

    task automatic add_random_call();
        int               r;
        logic [CMD_W-1:0] c;
        logic [PID_W-1:0] p;
        logic [OID_W-1:0] o;
        r = $urandom_range(0, 99);
        p = pick_live_pid();
        o = pick_object();
        if (r < 4) begin
            c = CMD_NEW_PROC;
        end else if (r < 5) begin
            // keep a few processes alive for the rest of the run
            c = CMD_END_PROC;
            if (plan_live_count() <= 4) p = PID_W'($urandom_range(N_PROC + 1, 31));
        end else if (r < 20) begin
            case ($urandom_range(0, 2))
                0:       c = CMD_NEW_MUTEX;
                1:       c = CMD_NEW_SEM;
                default: c = CMD_NEW_EVENT;
            endcase
        end else if (r < 90) begin
            c = $urandom_range(0, 1) ? CMD_WAIT : CMD_RELEASE;
            if (c == CMD_RELEASE && plan_waiter[o] != 0 && $urandom_range(0, 9) < 7)
                p = plan_waiter[o];
        end else if (r < 96) begin
            // noise over the whole field ranges, without killing live processes
            c = CMD_W'($urandom_range(0, 6));
            p = PID_W'($urandom_range(0, 31));
            o = OID_W'($urandom_range(0, 127));
            if (c == CMD_END_PROC && p >= 1 && p <= N_PROC) p = '0;
        end else begin
            c = CMD_UNDEF;
            p = PID_W'($urandom_range(0, 31));
            o = OID_W'($urandom_range(0, 127));
        end
        queue_call(c, p, o, rand_count(), rand_count(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    // stimulus build, reset and end of run
    initial begin
        for (int i = 1; i <= N_PROC; i++) begin
            tbl_live[i]  = 1'b0;
            plan_live[i] = 1'b0;
        end
        for (int i = 1; i <= N_OBJ; i++) begin
            tbl_kind[i]    = KIND_NONE;
            tbl_flag[i]    = 1'b0;
            tbl_manual[i]  = 1'b0;
            tbl_owner[i]   = '0;
            tbl_count[i]   = '0;
            tbl_limit[i]   = '0;
            plan_waiter[i] = '0;
        end
        tbl_next_pid  = 1;
        tbl_next_oid  = 1;
        plan_next_pid = 1;
        plan_next_oid = 1;

        // directed: bad identifiers, undefined command, each object kind at its edges
        gen_idle = 7'd32;
        queue_call(CMD_WAIT,      5'd0,  7'd0,   16'h0000, 16'hffff, 1'b0, 1'b0);
        queue_call(CMD_NEW_MUTEX, 5'd1,  7'd1,   16'hffff, 16'h0000, 1'b1, 1'b1);
        queue_call(CMD_UNDEF,     5'd31, 7'd127, 16'hffff, 16'hffff, 1'b1, 1'b1);
        queue_call(CMD_END_PROC,  5'd17, 7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_PROC,  5'd0,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_PROC,  5'd0,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_PROC,  5'd0,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_RELEASE,   5'd1,  7'd127, 16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd1,  7'd64,  16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_MUTEX, 5'd1,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd1,  7'd1,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd2,  7'd1,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_RELEASE,   5'd2,  7'd1,   16'h0000, 16'h0000, 1'b0, 1'b0);
        // owner ends while holding the mutex; it stays locked
        queue_call(CMD_END_PROC,  5'd1,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b0);
        // semaphore starting above its limit, then one starting empty
        queue_call(CMD_NEW_SEM,   5'd2,  7'd0,   16'hffff, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_RELEASE,   5'd2,  7'd2,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd2,  7'd2,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_SEM,   5'd3,  7'd0,   16'h0000, 16'hffff, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd3,  7'd3,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_RELEASE,   5'd3,  7'd3,   16'h0000, 16'h0000, 1'b0, 1'b0);
        // manual-reset event, then auto-reset event
        queue_call(CMD_NEW_EVENT, 5'd2,  7'd0,   16'h0000, 16'h0000, 1'b1, 1'b0);
        queue_call(CMD_WAIT,      5'd2,  7'd4,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_RELEASE,   5'd3,  7'd4,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd2,  7'd4,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd3,  7'd4,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_NEW_EVENT, 5'd3,  7'd0,   16'h0000, 16'h0000, 1'b0, 1'b1);
        queue_call(CMD_WAIT,      5'd3,  7'd5,   16'h0000, 16'h0000, 1'b0, 1'b0);
        queue_call(CMD_WAIT,      5'd2,  7'd5,   16'h0000, 16'h0000, 1'b0, 1'b0);

        // random: light sender idling, then heavy, then back to back
        for (int ph = 0; ph < 3; ph++) begin
            gen_idle  = (ph == 0) ? 7'd32 : (ph == 1) ? 7'd83 : 7'd0;
            gen_drain = 1'b1;
            for (int n = 0; n < PHASE_CALLS; n++) begin
                if ($urandom_range(0, 99) == 0) gen_drain = 1'b1;
                add_random_call();
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (call_q.size() != 0 || start || answer_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // driver: holds a command until its transfer, then takes the next one
    always @(negedge i_clk) begin : drive_proc
        t_call nxt;
        logic  go;
        nxt = drv_call;
        go  = 1'b0;
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (start && !xfer_seen) begin
            go = 1'b1;
        end else begin
            xfer_seen = 1'b0;
            if (call_q.size() != 0) begin
                if (call_q[0].drain && answer_q.size() != 0) begin
                    go = 1'b0;
                end else if ($urandom_range(0, 99) < call_q[0].idle) begin
                    go = 1'b0;
                end else begin
                    nxt = call_q.pop_front();
                    go  = 1'b1;
                end
            end
        end
        start           <= go;
        drv_call        <= nxt;
        i_cmd           <= nxt.cmd;
        i_process_id    <= nxt.pid;
        i_object_id     <= nxt.oid;
        i_initial_count <= nxt.init_cnt;
        i_maximum_count <= nxt.max_cnt;
        i_manual_reset  <= nxt.manual;
        i_initial_state <= nxt.istate;
    end

    task automatic note_mismatch(input string what, input int expv, input int gotv);
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, gotv);
    endtask

    // monitor: check results in order, predict each command on its transfer
    always @(posedge i_clk) begin : watch_proc
        t_answer want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (answer_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, %s%0d %s%0d %s%0d",
                             $time, "got ok=", o_ok, "status=", o_status,
                             "id=", o_new_id);
                end else begin
                    want = answer_q.pop_front();
                    if (o_ok !== want.ok) note_mismatch("ok", want.ok, o_ok);
                    if (o_status !== want.status) note_mismatch("status", want.status, o_status);
                    if (o_new_id !== want.new_id) note_mismatch("new_id", want.new_id, o_new_id);
                end
            end
            if (start && !busy) begin
                answer_q.insert(answer_q.size(), table_step(drv_call));
                xfer_seen = 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// File: files.f
hw/rtl/sot_pkg.sv
hw/rtl/sot_front.sv
hw/rtl/sot_queue.sv
hw/rtl/sot_back.sv
hw/rtl/sync_object_table.sv
verif/tb_top.sv
